// ===== rtl/latency_log2_histogram_defines.svh =====
// ---------------------------------------------------------------------------
// Latency histogram assertion macros
// Shared assertion forms for the latency histogram block.
// ---------------------------------------------------------------------------
`ifndef LATENCY_LOG2_HISTOGRAM_DEFINES_SVH
`define LATENCY_LOG2_HISTOGRAM_DEFINES_SVH

// Check a property outside of reset.
`define LLH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define LLH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/llh_pkg.sv =====
// ---------------------------------------------------------------------------
// Latency histogram package
// Widths, codes and defaults shared by the latency histogram block.
// ---------------------------------------------------------------------------
package llh_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int NUM_BINS_DEF    = 32;

  localparam int ACT_W   = 2;
  localparam int TAG_W   = 64;
  localparam int STAMP_W = 64;
  localparam int SEL_W   = 5;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 31;

  localparam logic [ACT_W-1:0] ACT_START = 2'd0;
  localparam logic [ACT_W-1:0] ACT_END   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_COUNTED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOSTART  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NEGATIVE = 3'd4;
  localparam logic [STAT_W-1:0] ST_BELOW    = 3'd5;
  localparam logic [STAT_W-1:0] ST_READ     = 3'd6;

  localparam logic CFG_MIN_LATENCY = 1'b0;
  localparam logic CFG_MICRO_MODE  = 1'b1;

  // Nanoseconds per microsecond and per millisecond.
  localparam int US_NS   = 1000;
  localparam int MS_NS   = 1000000;
  localparam int LOG_W   = 6;

  typedef struct packed {
    logic               vld;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] start;
  } pend_entry_t;

endpackage

// ===== rtl/latency_log2_histogram.sv =====
// ---------------------------------------------------------------------------
// Log2 latency histogram
// Pairs start and end items by tag, bins the latency by floor log2 in us or
// ms, and returns bin counts on read items.
// ---------------------------------------------------------------------------
// Accept to result: start and end items scan the tag table serially. Then a
// stored start passes WRITE, a full start or missing tag ends there, and a
// matched end passes DELTA and, if neither negative nor below threshold, LOG
// (one threshold compare per bin), HREAD and HUPD. Reads pass HREAD, HUPD.
// One item at a time: the next is taken the cycle after its result is loaded,
// which waits only while the output is stalled. Reset: clearing pass, no item taken.
module latency_log2_histogram #(
  parameter int TABLE_DEPTH = llh_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_BINS    = llh_pkg::NUM_BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [llh_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [llh_pkg::ACT_W-1:0]    action,
  input  logic [llh_pkg::TAG_W-1:0]    tag,
  input  logic [llh_pkg::STAMP_W-1:0]  stamp_ns,
  input  logic [llh_pkg::SEL_W-1:0]    bin_select,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [llh_pkg::STAT_W-1:0]   status,
  output logic [llh_pkg::SEL_W-1:0]    bin_hit,
  output logic [llh_pkg::COUNT_W-1:0]  bin_count
);
  import llh_pkg::*;

  `include "latency_log2_histogram_defines.svh"

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SA_W  = $clog2(TABLE_DEPTH + 1);
  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int CLR_N = (TABLE_DEPTH > NUM_BINS) ? TABLE_DEPTH : NUM_BINS;
  localparam int CLR_W = $clog2(CLR_N + 1);
  localparam int MIN_NS_W = CFG_W + 20;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_WRITE = 9'b000001000,
    S_DELTA = 9'b000010000,
    S_LOG   = 9'b000100000,
    S_HREAD = 9'b001000000,
    S_HUPD  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]    min_latency_ms;
  logic                micro_mode;
  logic [MIN_NS_W-1:0] min_ns;

  pend_entry_t pmem [TABLE_DEPTH];
  pend_entry_t prd;
  logic              pmem_we;
  logic [IDX_W-1:0]  pmem_waddr;
  pend_entry_t       pmem_wdata;

  logic [COUNT_W-1:0] hmem [NUM_BINS];
  logic [COUNT_W-1:0] h_rd;
  logic               hmem_we;
  logic [BIN_W-1:0]   h_addr;
  logic [COUNT_W-1:0] hmem_wdata;

  logic [CLR_W-1:0]   clr_cnt;

  logic [ACT_W-1:0]   act_r;
  logic [TAG_W-1:0]   tag_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [SEL_W-1:0]   sel_r;
  logic               sel_ok;

  logic [SA_W-1:0]    scan_addr;
  logic               pipe_vld;
  logic [IDX_W-1:0]   pipe_idx;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [STAMP_W-1:0] hit_start;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  logic [STAMP_W-1:0] delta;
  logic [STAMP_W-1:0] lg_thr;
  logic               lg_more;
  logic [LOG_W-1:0]   lg_cnt;
  logic [BIN_W-1:0]   bin_r;
  logic [BIN_W+4:0]   bin_wide;
  logic [BIN_W+4:0]   sel_wide;

  logic [STAT_W-1:0]  res_status;
  logic [SEL_W-1:0]   res_bin;
  logic [COUNT_W-1:0] res_count;

  logic in_accept;
  logic scan_done;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign scan_done = (scan_addr == SA_W'(TABLE_DEPTH)) && !pipe_vld;
  assign sel_wide  = (BIN_W + 5)'(bin_select);
  assign bin_wide  = (BIN_W + 5)'(bin_r);

  // Advance the bin while the next power-of-two threshold is still reached.
  assign lg_more = (lg_thr <= delta) &&
                   ({1'b0, lg_cnt} < (LOG_W + 1)'(NUM_BINS - 1));

  always_comb begin
    pmem_we    = 1'b0;
    pmem_waddr = hit ? hit_idx : free_idx;
    pmem_wdata = '0;
    hmem_we    = 1'b0;
    h_addr     = bin_r;
    hmem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        pmem_we    = (clr_cnt < CLR_W'(TABLE_DEPTH));
        pmem_waddr = clr_cnt[IDX_W-1:0];
        hmem_we    = (clr_cnt < CLR_W'(NUM_BINS));
        h_addr     = clr_cnt[BIN_W-1:0];
      end
      S_WRITE: begin
        pmem_we    = 1'b1;
        pmem_wdata = '{vld: 1'b1, tag: tag_r, start: stamp_r};
      end
      S_HUPD: begin
        if (act_r == ACT_END) begin
          pmem_we    = 1'b1;
          pmem_waddr = hit_idx;
          hmem_we    = 1'b1;
          hmem_wdata = h_rd + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pmem_we) begin
      pmem[pmem_waddr] <= pmem_wdata;
    end
    prd <= pmem[scan_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hmem_we) begin
      hmem[h_addr] <= hmem_wdata;
    end
    h_rd <= hmem[h_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_latency_ms <= '0;
      micro_mode     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LATENCY: min_latency_ms <= cfg_data;
        CFG_MICRO_MODE:  micro_mode     <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    min_ns <= MIN_NS_W'(min_latency_ms) * MIN_NS_W'(MS_NS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      scan_addr <= '0;
      pipe_vld  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            act_r      <= action;
            tag_r      <= tag;
            stamp_r    <= stamp_ns;
            sel_r      <= bin_select;
            sel_ok     <= (sel_wide < (BIN_W + 5)'(NUM_BINS));
            bin_r      <= sel_wide[BIN_W-1:0];
            res_bin    <= '0;
            res_count  <= '0;
            scan_addr  <= '0;
            pipe_vld   <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            case (action)
              ACT_START, ACT_END: state <= S_SCAN;
              ACT_READ:           state <= S_HREAD;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_addr != SA_W'(TABLE_DEPTH)) begin
            scan_addr <= scan_addr + 1'b1;
            pipe_vld  <= 1'b1;
            pipe_idx  <= scan_addr[IDX_W-1:0];
          end else begin
            pipe_vld <= 1'b0;
          end
          if (pipe_vld) begin
            if (prd.vld && prd.tag == tag_r) begin
              hit       <= 1'b1;
              hit_idx   <= pipe_idx;
              hit_start <= prd.start;
            end
            if (!prd.vld && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pipe_idx;
            end
          end
          if (scan_done) begin
            if (act_r == ACT_START) begin
              if (hit || free_found) begin
                state <= S_WRITE;
              end else begin
                res_status <= ST_FULL;
                state      <= S_OUT;
              end
            end else if (!hit) begin
              res_status <= ST_NOSTART;
              state      <= S_OUT;
            end else begin
              delta <= stamp_r - hit_start;
              state <= S_DELTA;
            end
          end
        end
        S_WRITE: begin
          res_status <= ST_STORED;
          state      <= S_OUT;
        end
        S_DELTA: begin
          if (delta[STAMP_W-1]) begin
            res_status <= ST_NEGATIVE;
            state      <= S_OUT;
          end else if (min_latency_ms != '0 && delta < STAMP_W'(min_ns)) begin
            res_status <= ST_BELOW;
            state      <= S_OUT;
          end else begin
            lg_thr <= micro_mode ? STAMP_W'(2 * US_NS) : STAMP_W'(2 * MS_NS);
            lg_cnt <= '0;
            state  <= S_LOG;
          end
        end
        S_LOG: begin
          if (lg_more) begin
            lg_thr <= {lg_thr[STAMP_W-2:0], 1'b0};
            lg_cnt <= lg_cnt + 1'b1;
          end else begin
            bin_r <= BIN_W'(lg_cnt);
            state <= S_HREAD;
          end
        end
        S_HREAD: begin
          state <= S_HUPD;
        end
        S_HUPD: begin
          if (act_r == ACT_END) begin
            res_status <= ST_COUNTED;
            res_bin    <= bin_wide[SEL_W-1:0];
            res_count  <= h_rd + 1'b1;
          end else begin
            res_status <= ST_READ;
            res_bin    <= sel_r;
            res_count  <= sel_ok ? h_rd : '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            status    <= res_status;
            bin_hit   <= res_bin;
            bin_count <= res_count;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `LLH_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == S_CLEAR) && !out_valid, "reset did not clear")
  `LLH_ASSERT(a_result_from_out, $rose(out_valid) |-> $past(state == S_OUT), "result outside OUT")
  `LLH_ASSERT(a_unused_action, (in_accept && action == ACT_NONE) |=> (state == S_IDLE), "unused action not dropped")
  `LLH_ASSERT(a_zero_fields, (out_valid && status != ST_COUNTED && status != ST_READ) |-> (bin_hit == '0 && bin_count == '0), "nonzero bin fields")

endmodule

// ===== tb/tb_latency_log2_histogram.sv =====
// ---------------------------------------------------------------------------
// Log2 latency histogram testbench
// Sends start, end and read events through the valid/stall input channel and
// checks every result against an internal pending-table and bin-count
// predictor or a value given in a short table of directed events, which come
// first. Random events then follow over six register settings, with random
// idling on both channels and one long output hold-off that backs up the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_latency_log2_histogram;
  import llh_pkg::*;

  localparam int TAG_POOL     = 96;
  localparam int CLEAR_WAIT   = 80;
  localparam int SETTLE       = 300;
  localparam int HOLD_CYCLES  = 200;
  localparam int WATCH_LIMIT  = 4000;
  localparam int QUIET_TAIL   = 150;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SEL_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
  } hist_result_t;

  typedef struct {
    logic [ACT_W-1:0]   act;
    logic [TAG_W-1:0]   tg;
    logic [STAMP_W-1:0] stamp;
    logic [SEL_W-1:0]   sel;
    bit                 typed;
    hist_result_t       res;
  } event_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [ACT_W-1:0]     action;
  logic [TAG_W-1:0]     tag;
  logic [STAMP_W-1:0]   stamp_ns;
  logic [SEL_W-1:0]     bin_select;
  logic                 out_valid;
  logic                 out_stall;
  logic [STAT_W-1:0]    status;
  logic [SEL_W-1:0]     bin_hit;
  logic [COUNT_W-1:0]   bin_count;

  // predictor state
  logic [CFG_W-1:0]     min_ms;
  logic                 micro;
  bit                   open_vld   [TABLE_DEPTH_DEF];
  logic [TAG_W-1:0]     open_tag   [TABLE_DEPTH_DEF];
  logic [STAMP_W-1:0]   open_start [TABLE_DEPTH_DEF];
  logic [COUNT_W-1:0]   bin_tally  [NUM_BINS_DEF];

  hist_result_t         due_results [$];
  event_row_t           directed_events [$];
  logic [TAG_W-1:0]     tag_pool [TAG_POOL];

  int                   mismatches;
  int                   events_sent;
  int                   results_seen;
  int                   status_seen [8];
  int                   idle_count;
  bit                   quiet;
  bit                   hold_req;
  bit                   tx_idle_on;

  latency_log2_histogram u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .tag        (tag),
    .stamp_ns   (stamp_ns),
    .bin_select (bin_select),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .bin_hit    (bin_hit),
    .bin_count  (bin_count)
  );

  always #10 clk = ~clk;

  function automatic bit histogram_step(input logic [ACT_W-1:0] act,
                                        input logic [TAG_W-1:0] tg,
                                        input logic [STAMP_W-1:0] st,
                                        input logic [SEL_W-1:0] sel,
                                        output hist_result_t r);
    int idx;
    int lg;
    logic [STAMP_W-1:0] delta;
    logic [STAMP_W-1:0] scaled;
    r = '0;
    idx = -1;
    for (int i = 0; i < TABLE_DEPTH_DEF; i++)
      if (idx < 0 && open_vld[i] && open_tag[i] == tg) idx = i;
    case (act)
      ACT_START: begin
        if (idx < 0)
          for (int i = 0; i < TABLE_DEPTH_DEF; i++)
            if (idx < 0 && !open_vld[i]) idx = i;
        if (idx < 0) begin
          r.status = ST_FULL;
        end else begin
          open_vld[idx]   = 1'b1;
          open_tag[idx]   = tg;
          open_start[idx] = st;
          r.status = ST_STORED;
        end
        return 1'b1;
      end
      ACT_END: begin
        if (idx < 0) begin
          r.status = ST_NOSTART;
          return 1'b1;
        end
        delta = st - open_start[idx];
        if (delta[STAMP_W-1]) begin
          r.status = ST_NEGATIVE;
          return 1'b1;
        end
        if (min_ms != '0 && delta / 64'd1000000 < {33'd0, min_ms}) begin
          r.status = ST_BELOW;
          return 1'b1;
        end
        scaled = micro ? delta / 64'd1000 : delta / 64'd1000000;
        lg = 0;
        while (scaled > 64'd1) begin
          scaled = scaled >> 1;
          lg++;
        end
        if (lg > NUM_BINS_DEF - 1) lg = NUM_BINS_DEF - 1;
        bin_tally[lg] = bin_tally[lg] + 1'b1;
        open_vld[idx] = 1'b0;
        r.status = ST_COUNTED;
        r.bin    = lg[SEL_W-1:0];
        r.count  = bin_tally[lg];
        return 1'b1;
      end
      ACT_READ: begin
        r.status = ST_READ;
        r.bin    = sel;
        r.count  = (sel < NUM_BINS_DEF) ? bin_tally[sel] : '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic event_row_t event_row(input logic [ACT_W-1:0] act,
                                           input logic [TAG_W-1:0] tg,
                                           input logic [STAMP_W-1:0] st,
                                           input logic [SEL_W-1:0] sel,
                                           input bit typed,
                                           input logic [STAT_W-1:0] stat,
                                           input logic [SEL_W-1:0] bin,
                                           input logic [COUNT_W-1:0] count);
    event_row_t row;
    row.act   = act;
    row.tg    = tg;
    row.stamp = st;
    row.sel   = sel;
    row.typed = typed;
    row.res   = '{status: stat, bin: bin, count: count};
    return row;
  endfunction

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_MIN_LATENCY) min_ms = data;
    else micro = data[0];
  endtask

  task automatic send_event(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] tg,
                            input logic [STAMP_W-1:0] st, input logic [SEL_W-1:0] sel,
                            input bit typed, input hist_result_t typed_res);
    hist_result_t pred;
    bit           has_result;
    @(negedge clk);
    if (tx_idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid   = 1'b1;
    action     = act;
    tag        = tg;
    stamp_ns   = st;
    bin_select = sel;
    do @(posedge clk); while (in_stall);
    has_result = histogram_step(act, tg, st, sel, pred);
    if (has_result) begin
      due_results.push_back(typed ? typed_res : pred);
      events_sent++;
    end
  endtask

  task automatic draw_event(input int start_pct, output logic [ACT_W-1:0] act,
                            output logic [TAG_W-1:0] tg, output logic [STAMP_W-1:0] st,
                            output logic [SEL_W-1:0] sel);
    int roll;
    int pick;
    int slot;
    int k;
    logic [STAMP_W-1:0] delta;
    roll = $urandom_range(0, 99);
    sel  = SEL_W'($urandom);
    tg   = {$urandom, $urandom};
    st   = {$urandom, $urandom};
    if (roll < 4) begin
      act = ACT_NONE;
    end else if (roll < 12) begin
      act = ACT_READ;
    end else if (roll < 12 + start_pct) begin
      act = ACT_START;
      if ($urandom_range(0, 9) != 0) tg = tag_pool[$urandom_range(0, TAG_POOL - 1)];
    end else begin
      act  = ACT_END;
      pick = -1;
      if ($urandom_range(0, 4) != 0) begin
        slot = $urandom_range(0, TABLE_DEPTH_DEF - 1);
        for (int i = 0; i < TABLE_DEPTH_DEF; i++)
          if (pick < 0 && open_vld[(slot + i) % TABLE_DEPTH_DEF])
            pick = (slot + i) % TABLE_DEPTH_DEF;
      end
      if (pick < 0) begin
        tg = tag_pool[$urandom_range(0, TAG_POOL - 1)];
      end else begin
        tg    = open_tag[pick];
        k     = $urandom_range(0, 62);
        delta = {$urandom, $urandom} >> (63 - k);
        if ($urandom_range(0, 9) == 0) st = open_start[pick] - delta - 64'd1;
        else st = open_start[pick] + delta;
      end
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    int window;
    bit rx_active;
    bit held;
    burst     = 0;
    window    = 0;
    rx_active = 1'b1;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (window == 0) begin
        rx_active = ($urandom_range(0, 2) != 0);
        window    = 48;
      end
      window--;
      if (hold_req && !held) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        held      = 1'b1;
        out_stall = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall = 1'b1;
      end else if (!quiet && rx_active && $urandom_range(0, 5) == 0) begin
        burst     = $urandom_range(1, 12) - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    hist_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      status_seen[status]++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, got status %0d bin %0d count %0d",
                 $time, status, bin_hit, bin_count);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (status !== want.status || bin_hit !== want.bin || bin_count !== want.count) begin
          $display("%0t: mismatch, expected status %0d bin %0d count %0d, got %0d %0d %0d",
                   $time, want.status, want.bin, want.count, status, bin_hit, bin_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_count <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCH_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, idle_count, due_results.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0]   phase_min   [NUM_PHASES];
    logic               phase_micro [NUM_PHASES];
    int                 phase_start [NUM_PHASES];
    int                 phase_items [NUM_PHASES];
    logic [ACT_W-1:0]   act;
    logic [TAG_W-1:0]   tg;
    logic [STAMP_W-1:0] st;
    logic [SEL_W-1:0]   sel;
    int                 sent;
    event_row_t         row;

    phase_min   = '{31'd0, 31'd0, 31'd1, 31'h7FFF_FFFF, 31'd3, 31'd0};
    phase_micro = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    phase_start = '{50, 50, 70, 45, 45, 45};
    phase_items = '{150, 180, 180, 180, 180, 230};

    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    action      = ACT_NONE;
    tag         = '0;
    stamp_ns    = '0;
    bin_select  = '0;
    min_ms      = '0;
    micro       = 1'b0;
    mismatches  = 0;
    events_sent = 0;
    results_seen = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    tx_idle_on  = 1'b1;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (open_vld[i]) begin
      open_vld[i]   = 1'b0;
      open_tag[i]   = '0;
      open_start[i] = '0;
    end
    foreach (bin_tally[i]) bin_tally[i] = '0;
    foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};

    directed_events.push_back(event_row(ACT_READ, 64'd0, 64'd0, 5'd0, 1, ST_READ, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_READ, 64'd0, 64'd0, 5'd31, 1, ST_READ, 5'd31, 32'd0));
    directed_events.push_back(event_row(ACT_END, 64'd5, 64'd1000, 5'd0, 1, ST_NOSTART, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_START, 64'd0, 64'd0, 5'd0, 1, ST_STORED, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_END, 64'd0, 64'd0, 5'd0, 1, ST_COUNTED, 5'd0, 32'd1));
    directed_events.push_back(event_row(ACT_START, '1, 64'd1000, 5'd0, 1, ST_STORED, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_END, '1, 64'd999, 5'd0, 1, ST_NEGATIVE, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_START, '1, 64'd0, 5'd0, 1, ST_STORED, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_END, '1, 64'h7FFF_FFFF_FFFF_FFFF, 5'd0, 1,
                                        ST_COUNTED, 5'd31, 32'd1));
    directed_events.push_back(event_row(ACT_END, '1, 64'd5, 5'd0, 1, ST_NOSTART, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_START, 64'h1234, '1, 5'd0, 1, ST_STORED, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_END, 64'h1234, 64'd0, 5'd0, 0, '0, '0, '0));
    directed_events.push_back(event_row(ACT_START, 64'hAAAA_5555_AAAA_5555, 64'd0, 5'd0, 1,
                                        ST_STORED, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_END, 64'hAAAA_5555_AAAA_5555, 64'd3_000_000, 5'd0,
                                        0, '0, '0, '0));
    directed_events.push_back(event_row(ACT_START, 64'd77, 64'd1000, 5'd0, 1, ST_STORED, 5'd0,
                                        32'd0));
    directed_events.push_back(event_row(ACT_END, 64'd77, 64'd1000 + (64'd1 << 40), 5'd0, 0,
                                        '0, '0, '0));
    directed_events.push_back(event_row(ACT_NONE, '1, '1, '1, 0, '0, '0, '0));
    directed_events.push_back(event_row(ACT_START, 64'd9, 64'd0, 5'd0, 1, ST_STORED, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_END, 64'd9, 64'h8000_0000_0000_0000, 5'd0, 1,
                                        ST_NEGATIVE, 5'd0, 32'd0));
    directed_events.push_back(event_row(ACT_READ, 64'd0, 64'd0, 5'd1, 0, '0, '0, '0));
    directed_events.push_back(event_row(ACT_READ, 64'd0, 64'd0, 5'd31, 0, '0, '0, '0));

    repeat (6) @(negedge clk);
    rst = 1'b0;
    repeat (CLEAR_WAIT) @(negedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) drain();
      write_reg(CFG_MIN_LATENCY, phase_min[p]);
      write_reg(CFG_MICRO_MODE, {{(CFG_W-1){1'b0}}, phase_micro[p]});
      if (p == 0) begin
        foreach (directed_events[i]) begin
          row = directed_events[i];
          send_event(row.act, row.tg, row.stamp, row.sel, row.typed, row.res);
        end
      end
      // long output hold-off while the sender keeps offering
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < phase_items[p]) begin
        if (sent % 32 == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
        if (p == NUM_PHASES - 1 && phase_items[p] - sent <= QUIET_TAIL) quiet = 1'b1;
        draw_event(phase_start[p], act, tg, st, sel);
        send_event(act, tg, st, sel, 1'b0, '0);
        if (act != ACT_NONE) sent++;
      end
    end

    drain();
    $display("covered %0d events over %0d register settings, %0d results checked",
             events_sent, NUM_PHASES, results_seen);
    $display("by status: stored %0d full %0d counted %0d no-start %0d negative %0d below %0d read %0d",
             status_seen[ST_STORED], status_seen[ST_FULL], status_seen[ST_COUNTED],
             status_seen[ST_NOSTART], status_seen[ST_NEGATIVE], status_seen[ST_BELOW],
             status_seen[ST_READ]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
